[hw/rtl/itda_pkg.sv]
// Shared types, character codes and sizing helpers for the decimal ASCII printer.
package itda_pkg;

    // Width of the value field on the port and the default conversion width.
    localparam int VALUE_W          = 64;
    localparam int VALUE_BITS_DEF   = 64;

    // log10(2) in Q12, used to size the digit register.
    localparam int LOG10_2_Q12      = 1233;

    // ASCII codes.
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Number of decimal digits needed to hold any value of the given bit width.
    function automatic int digits_for(input int bits);
        return ((bits * LOG10_2_Q12) >> 12) + 1;
    endfunction

    // Input item.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_signed;
        logic               add_newline;
    } itda_in_t;

    // Result item: one ASCII byte.
    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } itda_out_t;

    // Per-item text options handed from the converter to the emitter.
    typedef struct packed {
        logic neg;
        logic nl;
    } itda_flags_t;

endpackage

[hw/rtl/itda_conv.sv]
// Bit-serial binary to BCD converter (shift and add-3) with significant digit count.
module itda_conv
    import itda_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int NDIG       = digits_for(VALUE_BITS),
    parameter int CNTW       = $clog2(NDIG + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  is_signed,
    input  logic                  add_newline,
    output logic                  busy,
    output logic                  res_valid,
    input  logic                  res_take,
    output logic [NDIG*4-1:0]     bcd,
    output logic [CNTW-1:0]       ndig,
    output itda_flags_t           flags
);

    localparam int BCDW = NDIG * 4;
    localparam int IDXW = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int BITW = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } conv_state_t;

    conv_state_t           state_reg, state_next;
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCDW-1:0]       bcd_reg, bcd_next;
    logic [CNTW-1:0]       ndig_reg, ndig_next;
    logic [BITW-1:0]       cnt_reg, cnt_next;
    itda_flags_t           flags_reg, flags_next;

    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [BCDW-1:0]       corr;
    logic [BCDW-1:0]       shifted;
    logic [3:0]            top_dig;
    logic [IDXW-1:0]       top_idx;

    // Magnitude of the incoming value; the most negative value wraps to 2^(N-1).
    assign neg = is_signed & value[VALUE_BITS-1];
    assign mag = neg ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;

    // Add 3 to every digit of 5 or more, then shift in the next binary bit.
    always_comb
    begin
        for (int d = 0; d < NDIG; d++)
        begin
            corr[d*4 +: 4] = (bcd_reg[d*4 +: 4] >= 4'd5) ?
                             (bcd_reg[d*4 +: 4] + 4'd3) : bcd_reg[d*4 +: 4];
        end
        shifted = {corr[BCDW-2:0], bin_reg[VALUE_BITS-1]};
    end

    // The digit just above the current top is the only one that can become nonzero.
    assign top_idx = ndig_reg[IDXW-1:0];
    assign top_dig = shifted[top_idx*4 +: 4];

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        ndig_next  = ndig_reg;
        cnt_next   = cnt_reg;
        flags_next = flags_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    bin_next       = mag;
                    bcd_next       = '0;
                    ndig_next      = CNTW'(1);
                    cnt_next       = BITW'(VALUE_BITS);
                    flags_next.neg = neg;
                    flags_next.nl  = add_newline;
                    state_next     = S_RUN;
                end
            end
            S_RUN:
            begin
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
                bcd_next = shifted;
                if ((ndig_reg < CNTW'(NDIG)) && (top_dig != 4'd0))
                begin
                    ndig_next = ndig_reg + CNTW'(1);
                end
                cnt_next = cnt_reg - BITW'(1);
                if (cnt_reg == BITW'(1))
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bin_reg   <= '0;
            bcd_reg   <= '0;
            ndig_reg  <= CNTW'(1);
            cnt_reg   <= '0;
            flags_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bin_reg   <= bin_next;
            bcd_reg   <= bcd_next;
            ndig_reg  <= ndig_next;
            cnt_reg   <= cnt_next;
            flags_reg <= flags_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_HOLD);
    assign bcd       = bcd_reg;
    assign ndig      = ndig_reg;
    assign flags     = flags_reg;

endmodule

[hw/rtl/itda_emit.sv]
// Text emitter: sign, significant digits most significant first, optional newline.
module itda_emit
    import itda_pkg::*;
#(
    parameter int NDIG = digits_for(VALUE_BITS_DEF),
    parameter int CNTW = $clog2(NDIG + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_take,
    input  logic [NDIG*4-1:0] bcd,
    input  logic [CNTW-1:0]   ndig,
    input  itda_flags_t       flags,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output itda_out_t         rsp
);

    localparam int BCDW = NDIG * 4;
    localparam int IDXW = (NDIG > 1) ? $clog2(NDIG) : 1;

    typedef enum logic [1:0] {
        E_IDLE,
        E_SIGN,
        E_DIGITS,
        E_NEWLINE
    } emit_state_t;

    emit_state_t     state_reg;
    logic [BCDW-1:0] bcd_reg;
    logic [IDXW-1:0] idx_reg;
    logic            nl_reg;
    logic            valid_reg;
    itda_out_t       rsp_reg;

    logic            out_free;
    logic [3:0]      dig;

    // The output register can be loaded when empty or when its item leaves now.
    assign out_free = !valid_reg || !rsp_stall;
    assign src_take = (state_reg == E_IDLE) && src_valid;
    assign dig      = bcd_reg[idx_reg*4 +: 4];

    // State and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            bcd_reg   <= '0;
            idx_reg   <= '0;
            nl_reg    <= 1'b0;
            valid_reg <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            // Every state but idle puts a byte into a free output register.
            if (out_free)
            begin
                valid_reg <= (state_reg != E_IDLE);
            end
            case (state_reg)
                E_IDLE:
                begin
                    if (src_valid)
                    begin
                        bcd_reg   <= bcd;
                        idx_reg   <= IDXW'(ndig - CNTW'(1));
                        nl_reg    <= flags.nl;
                        state_reg <= flags.neg ? E_SIGN : E_DIGITS;
                    end
                end
                E_SIGN:
                begin
                    if (out_free)
                    begin
                        rsp_reg.char_out <= CH_MINUS;
                        rsp_reg.last     <= 1'b0;
                        state_reg        <= E_DIGITS;
                    end
                end
                E_DIGITS:
                begin
                    if (out_free)
                    begin
                        rsp_reg.char_out <= CH_ZERO + {4'd0, dig};
                        rsp_reg.last     <= (idx_reg == '0) && !nl_reg;
                        if (idx_reg == '0)
                        begin
                            state_reg <= nl_reg ? E_NEWLINE : E_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg - IDXW'(1);
                        end
                    end
                end
                E_NEWLINE:
                begin
                    if (out_free)
                    begin
                        rsp_reg.char_out <= CH_NEWLINE;
                        rsp_reg.last     <= 1'b1;
                        state_reg        <= E_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

[hw/rtl/integer_to_decimal_ascii.sv]
// Top level of the binary to decimal ASCII printer.
// Each accepted item is loaded into a shift-and-add-3 register that takes one
// bit per cycle, and its digits are then handed to the emitter. The emitter
// sends one byte per cycle through its output register while the output is
// not stalled: an optional '-', the significant digits, and an optional newline,
// 1 to 21 bytes in all at the default width, with last set on the final byte. The
// converter takes the next item as soon as its digits have been handed over, so
// conversion overlaps emission and the sustained rate is set by the converter
// when the output is not stalled. Bits of value above VALUE_BITS are ignored.
module integer_to_decimal_ascii
    import itda_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  itda_in_t  req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output itda_out_t rsp
);

    localparam int NDIG = digits_for(VALUE_BITS);
    localparam int CNTW = $clog2(NDIG + 1);

    logic              conv_busy;
    logic              conv_valid;
    logic              conv_take;
    logic [NDIG*4-1:0] conv_bcd;
    logic [CNTW-1:0]   conv_ndig;
    itda_flags_t       conv_flags;

    // Input is taken only while the converter is idle.
    assign req_stall = conv_busy;

    itda_conv #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG),
        .CNTW       (CNTW)
    ) u_conv (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (req_valid && !conv_busy),
        .value       (req.value[VALUE_BITS-1:0]),
        .is_signed   (req.is_signed),
        .add_newline (req.add_newline),
        .busy        (conv_busy),
        .res_valid   (conv_valid),
        .res_take    (conv_take),
        .bcd         (conv_bcd),
        .ndig        (conv_ndig),
        .flags       (conv_flags)
    );

    itda_emit #(
        .NDIG (NDIG),
        .CNTW (CNTW)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (conv_valid),
        .src_take  (conv_take),
        .bcd       (conv_bcd),
        .ndig      (conv_ndig),
        .flags     (conv_flags),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

[hw/rtl/itda_check.sv]
// Port-level checks for the decimal ASCII printer, bound to the top level.
module itda_check
    import itda_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input itda_out_t rsp
);

    // A stalled item stays in place unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled output item changed");

    // A minus sign always has digits after it.
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.char_out == CH_MINUS) |-> !rsp.last)
        else $error("minus sign marked last");

    // A newline always ends the text.
    a_newline_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.char_out == CH_NEWLINE) |-> rsp.last)
        else $error("newline not marked last");

    // The converter is busy right after it takes an item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("input taken again before conversion");

endmodule

bind integer_to_decimal_ascii itda_check u_itda_check (.*);
